>>> rtl/zcgr_pkg.sv
// Shared types and constants of the zero crossing gated recorder.
package zcgr_pkg;

    // Configuration register widths, reset values and indexes.
    localparam int FRAMES_W    = 17;
    localparam int STEP_W      = 25;
    localparam int SYNC_W      = 25;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 25;

    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_FRAMES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_STEP     = 2'd1;

    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 17'd65536;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 25'd256;

    // The sync ramp is unsigned with 24 fraction bits; this is 1.0.
    localparam logic [SYNC_W-1:0] SYNC_ONE = 25'd16777216;

    // Record stage codes.
    localparam int STAGE_W = 2;
    localparam logic [STAGE_W-1:0] STAGE_OFF     = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_MON_ON  = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_REC     = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_MON_OFF = 2'd3;

    typedef struct packed {
        logic [FRAMES_W-1:0] buffer_frames;
        logic [STEP_W-1:0]   ramp_step;
    } cfg_t;

    typedef struct packed {
        logic                write_enable;
        logic [STAGE_W-1:0]  record_stage;
    } status_t;

endpackage

>>> rtl/zcgr_in_if.sv
// Input channel: one audio sample and the control flag per beat.
interface zcgr_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic                          control_active;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output control_active, output sample, input ready);
    modport sink   (input valid, input control_active, input sample, output ready);
endinterface

>>> rtl/zcgr_out_if.sv
// Result channel: buffer write, sync ramp and record stage per beat.
interface zcgr_out_if #(
    parameter int SAMPLE_BITS = 24,
    parameter int ADDR_W      = 16
);
    logic                          valid;
    logic                          ready;
    logic                          write_enable;
    logic [ADDR_W-1:0]             write_address;
    logic signed [SAMPLE_BITS-1:0] write_data;
    logic [24:0]                   sync_value;
    logic [1:0]                    record_stage;

    modport source (output valid, output write_enable, output write_address,
                    output write_data, output sync_value, output record_stage,
                    input ready);
    modport sink   (input valid, input write_enable, input write_address,
                    input write_data, input sync_value, input record_stage,
                    output ready);
endinterface

>>> rtl/zcgr_cfg_if.sv
// Configuration write channel: register index and write data per beat.
interface zcgr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [24:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/zcgr_cfg_regs.sv
// Configuration registers: buffer length and sync ramp step.
module zcgr_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    zcgr_cfg_if.sink      cfg,
    output zcgr_pkg::cfg_t cfg_values
);
    import zcgr_pkg::*;

    logic [FRAMES_W-1:0] frames_reg;
    logic [STEP_W-1:0]   step_reg;

    // Writes are always taken; an index outside the list is dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_RESET;
            step_reg   <= STEP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_BUFFER_FRAMES: frames_reg <= cfg.data[FRAMES_W-1:0];
                CFG_RAMP_STEP:     step_reg   <= cfg.data[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    assign cfg_values.buffer_frames = frames_reg;
    assign cfg_values.ramp_step     = step_reg;

endmodule

>>> rtl/zcgr_core.sv
// Record stage machine, ring position and sync ramp for one sample.
module zcgr_core #(
    parameter int MAX_FRAMES  = 65536,
    parameter int SAMPLE_BITS = 24,
    parameter int ADDR_W      = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          control_active,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  zcgr_pkg::cfg_t                cfg_values,
    output zcgr_pkg::status_t             status,
    output logic [ADDR_W-1:0]             write_address,
    output logic signed [SAMPLE_BITS-1:0] write_data,
    output logic [zcgr_pkg::SYNC_W-1:0]   sync_value
);
    import zcgr_pkg::*;

    localparam int LEN_W = (FRAMES_W > ADDR_W + 1) ? FRAMES_W : ADDR_W + 1;

    logic [STAGE_W-1:0] stage_reg, stage_next, stage_mid;
    logic               prev_ctrl_reg;
    logic               prev_neg_reg;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [SYNC_W-1:0]  sync_acc_reg, sync_acc_next;

    logic               negative;
    logic               crossing;
    logic               write;
    logic [LEN_W-1:0]   frames_ext;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   pos_inc;
    logic [SYNC_W:0]    sync_sum;

    assign negative = sample[SAMPLE_BITS-1];
    assign crossing = prev_neg_reg && !negative;

    // A change of the control flag toggles between the paired stages.
    always_comb
    begin
        stage_mid = stage_reg;
        if (control_active != prev_ctrl_reg)
        begin
            case (stage_reg)
                STAGE_OFF:     stage_mid = STAGE_MON_ON;
                STAGE_MON_ON:  stage_mid = STAGE_OFF;
                STAGE_REC:     stage_mid = STAGE_MON_OFF;
                default:       stage_mid = STAGE_REC;
            endcase
        end
    end

    // A positive zero crossing ends either monitoring stage.
    always_comb
    begin
        stage_next = stage_mid;
        if (stage_mid[0] && crossing)
        begin
            stage_next = (stage_mid == STAGE_MON_ON) ? STAGE_REC : STAGE_OFF;
        end
    end

    assign write = stage_next[1];

    // Buffer length is limited to the storage the block addresses.
    assign frames_ext = LEN_W'(cfg_values.buffer_frames);
    assign len        = (frames_ext > LEN_W'(MAX_FRAMES)) ? LEN_W'(MAX_FRAMES) : frames_ext;
    assign pos_inc    = LEN_W'(pos_reg) + LEN_W'(1);
    assign pos_next   = (pos_inc >= len) ? '0 : pos_inc[ADDR_W-1:0];

    assign sync_sum      = {1'b0, sync_acc_reg} + {1'b0, cfg_values.ramp_step};
    assign sync_acc_next = (sync_sum > {1'b0, SYNC_ONE}) ? '0 : sync_sum[SYNC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= STAGE_OFF;
            prev_ctrl_reg <= 1'b0;
            prev_neg_reg  <= 1'b0;
            pos_reg       <= '0;
            sync_acc_reg  <= '0;
        end
        else if (advance)
        begin
            stage_reg     <= stage_next;
            prev_ctrl_reg <= control_active;
            prev_neg_reg  <= negative;
            if (write)
            begin
                pos_reg      <= pos_next;
                sync_acc_reg <= sync_acc_next;
            end
        end
    end

    assign status.write_enable = write;
    assign status.record_stage = stage_next;
    assign write_address       = write ? pos_reg : '0;
    assign write_data          = write ? sample : '0;
    assign sync_value          = write ? sync_acc_next : sync_acc_reg;

    // The ramp is folded back to zero as soon as it passes 1.0.
    a_sync_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sync_acc_reg <= SYNC_ONE)
        else $error("sync ramp above 1.0");

    // Position and ramp move only on a written sample.
    a_hold_without_write: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !write) |=> ($stable(pos_reg) && $stable(sync_acc_reg)))
        else $error("position or ramp moved without a write");

    // Monitor-off is reached only from recording or monitor-off.
    a_no_mon_off_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !stage_reg[1]) |-> (stage_next != STAGE_MON_OFF))
        else $error("monitor-off entered from a non-recording stage");

endmodule

>>> rtl/zero_crossing_gated_recorder.sv
// Top level of the zero crossing gated recorder.
//
// The recorder takes one audio sample and a control flag per input beat and
// returns exactly one result beat for each: a buffer write (enable, ring
// address, sample), the sync ramp value and the record stage as it stands
// after that sample. It sustains one sample per clock cycle while results are
// taken; a sample is captured in the input register at the edge that accepts
// it, passes into the result register once that register is free or its beat
// is being taken, and its result beat is presented from then on. The stage,
// ring position and ramp update all sit in the single path between those two
// registers, which is what keeps a new sample every cycle while results are
// taken. The input channel is ready whenever the input register is empty or
// its sample moves on to the result register in the same cycle, so a held
// result only stalls the input once both registers are full. Configuration
// writes (buffer length, sync step) are always accepted and take effect from
// the next sample; they are meant to be made while no sample is in flight.
module zero_crossing_gated_recorder #(
    parameter int MAX_FRAMES  = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    zcgr_cfg_if.sink   cfg,
    zcgr_in_if.sink    item,
    zcgr_out_if.source result
);
    import zcgr_pkg::*;

    localparam int ADDR_W = $clog2(MAX_FRAMES);

    // Input register.
    logic                          in_valid_reg;
    logic                          in_ctrl_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;

    // Result register.
    logic                          out_valid_reg;
    logic                          out_we_reg;
    logic [ADDR_W-1:0]             out_addr_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;
    logic [SYNC_W-1:0]             out_sync_reg;
    logic [STAGE_W-1:0]            out_stage_reg;

    logic                          advance;
    cfg_t                          cfg_values;
    status_t                       status;
    logic [ADDR_W-1:0]             core_addr;
    logic signed [SAMPLE_BITS-1:0] core_data;
    logic [SYNC_W-1:0]             core_sync;

    zcgr_cfg_regs u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_values (cfg_values)
    );

    // The held sample moves on whenever the result register is free or
    // its beat is being taken in this cycle.
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_ctrl_reg   <= item.control_active;
            in_sample_reg <= item.sample;
        end
    end

    zcgr_core #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_W      (ADDR_W)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .control_active (in_ctrl_reg),
        .sample         (in_sample_reg),
        .cfg_values     (cfg_values),
        .status         (status),
        .write_address  (core_addr),
        .write_data     (core_data),
        .sync_value     (core_sync)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_we_reg    <= status.write_enable;
            out_addr_reg  <= core_addr;
            out_data_reg  <= core_data;
            out_sync_reg  <= core_sync;
            out_stage_reg <= status.record_stage;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.write_enable  = out_we_reg;
    assign result.write_address = out_addr_reg;
    assign result.write_data    = out_data_reg;
    assign result.sync_value    = out_sync_reg;
    assign result.record_stage  = out_stage_reg;

    // A write is only issued while recording or monitoring off.
    a_write_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_we_reg) |-> out_stage_reg[1])
        else $error("write issued outside a recording stage");

    // A result without a write carries zero address and data.
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_we_reg) |-> (out_addr_reg == '0 && out_data_reg == '0))
        else $error("address or data set without a write");

    // A sample only advances when the result register can take it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !advance)
        else $error("result register overwritten while held");

endmodule

>>> tb/sv/recorder_checker.sv
// Checker for the zero crossing gated recorder: predicts every result beat and compares it.
`timescale 1ns / 1ps

module recorder_checker (
    input  logic clk,
    input  logic rst_n,
    zcgr_cfg_if  cfg,
    zcgr_in_if   item,
    zcgr_out_if  result,
    output int   failures,
    output int   outstanding
);
    import zcgr_pkg::*;

    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_W      = 16;

    // Longest record buffer that the ring position honours.
    localparam logic [FRAMES_W-1:0] FRAME_CAP = 17'd65536;

    typedef struct packed {
        logic                          write_enable;
        logic [ADDR_W-1:0]             write_address;
        logic signed [SAMPLE_BITS-1:0] write_data;
        logic [SYNC_W-1:0]             sync_value;
        logic [STAGE_W-1:0]            record_stage;
    } recorder_beat_t;

    // Register copies and recorder state as the block should hold them.
    logic [FRAMES_W-1:0] cfg_frames;
    logic [STEP_W-1:0]   cfg_step;
    logic [STAGE_W-1:0]  model_stage;
    logic                last_ctrl;
    logic                last_negative;
    logic [ADDR_W-1:0]   ring_pos;
    logic [SYNC_W-1:0]   ramp;

    recorder_beat_t awaited_beats[$];
    recorder_beat_t want;
    int             mismatches = 0;

    // Moves the stage machine for one sample and works out the beat it yields.
    function automatic recorder_beat_t advance_recorder(
        input logic                          ctrl,
        input logic signed [SAMPLE_BITS-1:0] smp
    );
        logic [FRAMES_W-1:0] span;
        logic [FRAMES_W-1:0] next_pos;
        logic [SYNC_W:0]     ramp_sum;
        recorder_beat_t      beat;

        beat = '0;
        if (ctrl != last_ctrl)
        begin
            case (model_stage)
                STAGE_OFF:    model_stage = STAGE_MON_ON;
                STAGE_MON_ON: model_stage = STAGE_OFF;
                STAGE_REC:    model_stage = STAGE_MON_OFF;
                default:      model_stage = STAGE_REC;
            endcase
        end

        // A rising zero crossing only matters in the two monitor stages.
        if ((model_stage == STAGE_MON_ON || model_stage == STAGE_MON_OFF)
            && last_negative && !smp[SAMPLE_BITS-1])
        begin
            model_stage = (model_stage == STAGE_MON_ON) ? STAGE_REC : STAGE_OFF;
        end

        if (model_stage == STAGE_REC || model_stage == STAGE_MON_OFF)
        begin
            span = (cfg_frames > FRAME_CAP) ? FRAME_CAP : cfg_frames;
            beat.write_enable  = 1'b1;
            beat.write_address = ring_pos;
            beat.write_data    = smp;
            next_pos = {1'b0, ring_pos} + 17'd1;
            ring_pos = (next_pos >= span) ? '0 : next_pos[ADDR_W-1:0];
            ramp_sum = {1'b0, ramp} + {1'b0, cfg_step};
            ramp = (ramp_sum > {1'b0, SYNC_ONE}) ? '0 : ramp_sum[SYNC_W-1:0];
        end

        last_ctrl     = ctrl;
        last_negative = smp[SAMPLE_BITS-1];
        beat.sync_value   = ramp;
        beat.record_stage = model_stage;
        return beat;
    endfunction

    function automatic void compare_field(
        input string       label,
        input logic [31:0] expected_value,
        input logic [31:0] actual_value
    );
        if (actual_value !== expected_value)
        begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h",
                     $time, label, expected_value, actual_value);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_frames    = FRAMES_RESET;
            cfg_step      = STEP_RESET;
            model_stage   = STAGE_OFF;
            last_ctrl     = 1'b0;
            last_negative = 1'b0;
            ring_pos      = '0;
            ramp          = '0;
            awaited_beats.delete();
            outstanding <= 0;
            failures    <= mismatches;
        end
        else
        begin
            // Results first: a sample accepted at this edge cannot have its beat here yet.
            if (result.valid && result.ready)
            begin
                if (awaited_beats.size() == 0)
                begin
                    $display("%0t ns: result beat with no sample awaiting it", $time);
                    mismatches++;
                end
                else
                begin
                    want = awaited_beats.pop_front();
                    compare_field("write_enable", 32'(want.write_enable),
                                  32'(result.write_enable));
                    compare_field("write_address", 32'(want.write_address),
                                  32'(result.write_address));
                    compare_field("write_data", 32'(want.write_data),
                                  32'(result.write_data));
                    compare_field("sync_value", 32'(want.sync_value),
                                  32'(result.sync_value));
                    compare_field("record_stage", 32'(want.record_stage),
                                  32'(result.record_stage));
                end
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_BUFFER_FRAMES: cfg_frames = cfg.data[FRAMES_W-1:0];
                    CFG_RAMP_STEP:     cfg_step   = cfg.data[STEP_W-1:0];
                    default:           ;
                endcase
            end

            if (item.valid && item.ready)
                awaited_beats.push_back(advance_recorder(item.control_active, item.sample));

            outstanding <= awaited_beats.size();
            failures    <= mismatches;
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the recorder testbench: clock, reset, sample and register stimulus, and the verdict.
`timescale 1ns / 1ps

module testbench;
    import zcgr_pkg::*;

    localparam int SAMPLE_BITS   = 24;
    localparam int PHASE_SAMPLES = 140;
    // Cycles the result side is held off in one go, well beyond the two beats of storage.
    localparam int LONG_HOLD     = 300;
    // Extra wait after the final drain; a sample passes through the input and result registers.
    localparam int DRAIN_SLACK   = 8;
    localparam int RUN_LIMIT_NS  = 2000000;

    // A register index with nothing behind it; writes to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd2;

    logic clk = 1'b0;
    logic rst_n;

    zcgr_cfg_if cfg_bus ();
    zcgr_in_if  sample_bus ();
    zcgr_out_if result_bus ();

    int failures;
    int beats_awaited;

    int unsigned source_idle_pct = 0;
    int unsigned sink_idle_pct   = 0;
    logic        hold_request    = 1'b0;
    logic        ctrl_level      = 1'b0;
    int unsigned samples_sent    = 0;
    int unsigned register_writes = 0;
    int unsigned phases_run      = 0;

    zero_crossing_gated_recorder uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .item   (sample_bus),
        .result (result_bus)
    );

    recorder_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_bus),
        .item        (sample_bus),
        .result      (result_bus),
        .failures    (failures),
        .outstanding (beats_awaited)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side. It drops ready at random according to the current idle
    // percentage, and once asked it holds ready low for a long stretch so
    // that both internal registers fill and the sample side has to stall.
    initial
    begin : result_sink
        int unsigned held;

        held = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && held < LONG_HOLD)
            begin
                held++;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Sample values. Random words cover every bit; the extremes turn up now and then.
    function automatic logic signed [SAMPLE_BITS-1:0] any_sample();
        logic [31:0] raw;

        raw = $urandom();
        if (raw[31:28] == 4'hF)
        begin
            case (raw[1:0])
                2'd0:    return 24'h800000;
                2'd1:    return 24'h7FFFFF;
                2'd2:    return 24'h000000;
                default: return 24'hFFFFFF;
            endcase
        end
        return raw[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] negative_sample();
        logic [SAMPLE_BITS-1:0] magnitude;

        magnitude = SAMPLE_BITS'($urandom_range(32'h7FFFFF));
        return ~magnitude;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] nonnegative_sample();
        logic [SAMPLE_BITS-1:0] magnitude;

        magnitude = SAMPLE_BITS'($urandom_range(32'h7FFFFF));
        return magnitude;
    endfunction

    // Offers one sample beat, after a random idle gap, and returns once it is taken.
    task automatic send_sample(
        input logic                          ctrl,
        input logic signed [SAMPLE_BITS-1:0] smp
    );
        while ($urandom_range(99) < source_idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid          <= 1'b1;
        sample_bus.control_active <= ctrl;
        sample_bus.sample         <= smp;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        ctrl_level = ctrl;
        samples_sent++;
    endtask

    // Stops offering samples until every predicted beat has come back. The
    // first wait is unconditional because the count seen at this edge does
    // not yet include a sample taken at this same edge.
    task automatic wait_until_drained();
        sample_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (beats_awaited != 0);
    endtask

    // One register beat. Valid is left high so that back-to-back writes never
    // lower and raise it in the same step; the caller lowers it afterwards.
    task automatic write_register(
        input logic [CFG_INDEX_W-1:0] idx,
        input logic [CFG_DATA_W-1:0]  value
    );
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        register_writes++;
    endtask

    // A complete take: arm the monitor by flipping the control, wait for a
    // rising zero crossing to start recording, record for a while, flip the
    // control again to enter monitor-off, and let a second crossing end it.
    // The content of every sample other than the crossings is random.
    task automatic record_take();
        int unsigned lead;
        int unsigned body;
        int unsigned tail;

        send_sample(!ctrl_level, any_sample());
        lead = $urandom_range(1, 3);
        repeat (lead)
            send_sample(ctrl_level, negative_sample());
        send_sample(ctrl_level, nonnegative_sample());
        body = $urandom_range(1, 40);
        repeat (body)
            send_sample(ctrl_level, any_sample());
        send_sample(!ctrl_level, any_sample());
        tail = $urandom_range(0, 4);
        repeat (tail)
            send_sample(ctrl_level, negative_sample());
        send_sample(ctrl_level, nonnegative_sample());
        tail = $urandom_range(0, 3);
        repeat (tail)
            send_sample(ctrl_level, any_sample());
    endtask

    // Short bursts with a random control flag, which toggle the stage machine
    // at odd moments and break takes off half way.
    task automatic line_noise();
        int unsigned burst;

        burst = $urandom_range(1, 8);
        repeat (burst)
            send_sample(1'($urandom_range(1)), any_sample());
    endtask

    // One register setting. The block is drained before the registers are
    // touched, then the phase runs mostly complete takes and some noise.
    // Half way through, the phase may pause until everything is back, or
    // ask the result side for its long hold-off.
    task automatic run_phase(
        input logic [CFG_DATA_W-1:0] frames,
        input logic [CFG_DATA_W-1:0] step,
        input int unsigned           src_pct,
        input int unsigned           snk_pct,
        input bit                    poke_spare,
        input bit                    pause_midway,
        input bit                    hold_midway
    );
        int unsigned midway;
        int unsigned target;

        wait_until_drained();
        write_register(CFG_BUFFER_FRAMES, frames);
        write_register(CFG_RAMP_STEP, step);
        if (poke_spare)
            write_register(CFG_SPARE, ~frames);
        cfg_bus.valid <= 1'b0;
        source_idle_pct = src_pct;
        sink_idle_pct   = snk_pct;
        phases_run++;

        midway = samples_sent + PHASE_SAMPLES / 2;
        target = samples_sent + PHASE_SAMPLES;
        while (samples_sent < target)
        begin
            if (samples_sent >= midway)
            begin
                if (pause_midway)
                    wait_until_drained();
                if (hold_midway)
                    hold_request <= 1'b1;
                midway = target;
            end
            if ($urandom_range(9) < 8)
                record_take();
            else
                line_noise();
        end
    endtask

    initial
    begin : stimulus
        rst_n                     = 1'b0;
        sample_bus.valid          = 1'b0;
        sample_bus.control_active = 1'b0;
        sample_bus.sample         = '0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.index             = CFG_BUFFER_FRAMES;
        cfg_bus.data              = '0;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through the stage machine at the reset settings.
        // Off ignores crossings, including one from the most negative to the
        // most positive sample.
        send_sample(1'b0, 24'h000000);
        send_sample(1'b0, 24'h800000);
        send_sample(1'b0, 24'h7FFFFF);
        // Arm, then a crossing onto exactly zero starts recording.
        send_sample(1'b1, 24'hFFFFFF);
        send_sample(1'b1, 24'h000000);
        send_sample(1'b1, 24'h7FFFFF);
        send_sample(1'b1, 24'h800000);
        // Monitor-off still writes, and flipping back returns to recording.
        send_sample(1'b0, -24'sd5);
        send_sample(1'b1, -24'sd7);
        send_sample(1'b0, -24'sd3);
        // A crossing in monitor-off stops the take.
        send_sample(1'b0, 24'sd100);
        // Armed and disarmed again without a crossing.
        send_sample(1'b1, -24'sd2);
        send_sample(1'b0, -24'sd2);
        // Arming and a crossing on the same sample go straight to recording.
        send_sample(1'b1, 24'h123456);
        send_sample(1'b1, -24'sd1);
        // Leaving recording and a crossing on the same sample end at off.
        send_sample(1'b0, 24'sd1);

        // The ring position left by the walk above lies beyond the one-entry
        // buffer of the first phase, so the first write there uses the held
        // position before wrapping. A one-step ramp wraps at once from the walk's
        // value, then alternates 1.0 and zero; an empty buffer writes everything to
        // the first entry; a length above the cap is treated as the cap.
        run_phase(25'd1, 25'd16777216, 13, 85, 1'b0, 1'b0, 1'b0);
        run_phase(25'd0, 25'h1FFFFFF, 13, 85, 1'b1, 1'b1, 1'b0);
        run_phase(25'h001FFFF, 25'd0, 85, 13, 1'b0, 1'b0, 1'b0);
        // Bits above the buffer length field are set here and must be dropped.
        run_phase(25'h0AA0003, 25'd5592405, 85, 13, 1'b0, 1'b0, 1'b0);
        run_phase(25'd7, CFG_DATA_W'($urandom_range(32'h1FFFFFF)), 0, 0,
                  1'b0, 1'b0, 1'b1);
        run_phase(25'd65536, 25'd256, 0, 0, 1'b0, 1'b0, 1'b0);

        wait_until_drained();
        repeat (DRAIN_SLACK)
            @(posedge clk);

        $display("tb: %0d samples in %0d register settings, %0d register writes,",
                 samples_sent, phases_run, register_writes);
        $display("tb: buffer lengths 0 to above the cap, ramp steps 0 to full scale, stalls");
        if (failures == 0 && beats_awaited == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb: run did not finish in time");
        $display("tb: failure");
        $finish;
    end

endmodule
